// File: sv/pru_pkg.sv
// Shared types and constants for the pixel replicating upscaler.
`timescale 1ns / 1ps

package pru_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned MaxScale = 16;

  localparam int unsigned ColW   = $clog2(MaxWidth);  // line store address
  localparam int unsigned CntW   = $clog2(MaxScale);  // copy counters
  localparam int unsigned ScaleW = 5;
  localparam int unsigned WidthW = 11;
  localparam int unsigned CfgW   = WidthW;             // config data width

  typedef enum logic [0:0] {
    CfgScale = 1'b0,
    CfgWidth = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ActFill   = 1'b0,
    ActReplay = 1'b1
  } action_e;

  typedef enum logic [0:0] {
    StatOk        = 1'b0,
    StatWrongKind = 1'b1
  } status_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Line store access, one port: either a write or a read per cycle
  typedef struct packed {
    logic            we;
    logic            re;
    logic [ColW-1:0] addr;
    pixel_t          wdata;
  } mem_req_t;

endpackage

// File: sv/pru_line_store.sv
// Single-port line store holding one input line of pixels.
`timescale 1ns / 1ps

module pru_line_store (
  input  logic              clk_i,
  input  pru_pkg::mem_req_t req_i,
  output pru_pkg::pixel_t   rdata_o
);

  pru_pkg::pixel_t mem [pru_pkg::MaxWidth];
  pru_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pixel_replicating_upscaler_core.sv
// Top level: nearest-neighbour integer upscaler with line store replay.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o  | action, red_in, green_in, blue_in
//  out     | output    | out_valid_o / out_stall_i| rgb out, line_end, run_last, status
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  An item gives scale beats on the output side (one for a wrong-kind item); the
//  staging register can take a new item while the output run is still busy.
//  An accepted item passes the staging register, then the output run register.
//  Reset clears mode, column and copy state; the line store is not cleared.
//  out_stall_i holds the current beat; in_stall_o rises once the staging register
//  is full and the output run is busy and not handing over its last beat.
`timescale 1ns / 1ps

module pixel_replicating_upscaler_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [7:0]               red_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               blue_in_i,
  // output beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               red_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               blue_out_o,
  output logic                     line_end_o,
  output logic                     run_last_o,
  output logic                     status_o,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [0:0]               cfg_index_i,
  input  logic [pru_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned ColW   = pru_pkg::ColW;
  localparam int unsigned CntW   = pru_pkg::CntW;
  localparam int unsigned ScaleW = pru_pkg::ScaleW;
  localparam int unsigned WidthW = pru_pkg::WidthW;

  // configuration registers
  logic [ScaleW-1:0] scale_q;
  logic [WidthW-1:0] width_q;

  // line state
  logic [ColW-1:0] col_q, col_d;
  logic [CntW-1:0] copies_q, copies_d;
  logic            replay_q, replay_d;

  // staging register
  logic            s1_valid_q;
  logic            s1_err_q;
  logic            s1_replay_q;
  logic            s1_end_q;
  logic [CntW-1:0] s1_nm1_q;
  pru_pkg::pixel_t s1_pix_q;

  // output run register
  logic            out_valid_q;
  logic            out_err_q;
  logic            out_end_q;
  logic [CntW-1:0] out_nm1_q;
  logic [CntW-1:0] cnt_q;
  pru_pkg::pixel_t out_pix_q;

  logic [ScaleW-1:0] scale_eff;
  logic [WidthW-1:0] width_eff;
  logic              in_acc, wrong_kind, line_done;
  logic [ScaleW-1:0] copies_inc;
  logic              out_last, out_fire, out_free, s1_adv;
  pru_pkg::mem_req_t mem_req;
  pru_pkg::pixel_t   mem_rdata, in_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleW'(1);
      width_q <= WidthW'(1);
    end else if (cfg_valid_i) begin
      case (pru_pkg::cfg_idx_e'(cfg_index_i))
        pru_pkg::CfgScale: scale_q <= cfg_data_i[ScaleW-1:0];
        pru_pkg::CfgWidth: width_q <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range settings clamp to the nearest legal value
  always_comb begin
    if (scale_q == '0) begin
      scale_eff = ScaleW'(1);
    end else if (scale_q > ScaleW'(pru_pkg::MaxScale)) begin
      scale_eff = ScaleW'(pru_pkg::MaxScale);
    end else begin
      scale_eff = scale_q;
    end
    if (width_q == '0) begin
      width_eff = WidthW'(1);
    end else if (width_q > WidthW'(pru_pkg::MaxWidth)) begin
      width_eff = WidthW'(pru_pkg::MaxWidth);
    end else begin
      width_eff = width_q;
    end
  end

  // output side handshake
  assign out_last = (cnt_q == out_nm1_q);
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || (out_fire && out_last);
  assign s1_adv   = s1_valid_q && out_free;

  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wrong_kind = (action_i != replay_q);
  assign line_done  = ({1'b0, col_q} + WidthW'(1)) >= width_eff;
  assign copies_inc = {1'b0, copies_q} + ScaleW'(1);
  assign in_pix     = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  always_comb begin
    col_d    = col_q;
    copies_d = copies_q;
    replay_d = replay_q;
    if (in_acc && !wrong_kind) begin
      if (!line_done) begin
        col_d = col_q + ColW'(1);
      end else begin
        col_d = '0;
        if (copies_inc >= scale_eff) begin
          copies_d = '0;
          replay_d = 1'b0;
        end else begin
          copies_d = copies_inc[CntW-1:0];
          replay_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      copies_q <= '0;
      replay_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      copies_q <= copies_d;
      replay_q <= replay_d;
    end
  end

  always_comb begin
    mem_req.we    = in_acc && !wrong_kind && !replay_q;
    mem_req.re    = in_acc && !wrong_kind && replay_q;
    mem_req.addr  = col_q;
    mem_req.wdata = in_pix;
  end

  pru_line_store u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  // staging register, alongside the registered store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_err_q    <= wrong_kind;
      s1_replay_q <= replay_q && !wrong_kind;
      s1_end_q    <= line_done && !wrong_kind;
      s1_nm1_q    <= wrong_kind ? '0 : CntW'(scale_eff - ScaleW'(1));
      s1_pix_q    <= wrong_kind ? '0 : in_pix;
    end
  end

  // output run: one beat per copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_err_q <= s1_err_q;
      out_end_q <= s1_end_q;
      out_nm1_q <= s1_nm1_q;
      out_pix_q <= s1_replay_q ? mem_rdata : s1_pix_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;
  assign line_end_o  = out_end_q && out_last;
  assign run_last_o  = out_last;
  assign status_o    = out_err_q ? pru_pkg::StatWrongKind : pru_pkg::StatOk;

  // copies of the line are only outstanding while replaying
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q == (copies_q != '0))
    else $error("replay mode and copy count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (cnt_q <= out_nm1_q))
    else $error("copy counter ran past end of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_o |-> run_last_o && !line_end_o)
    else $error("wrong-kind result must be a single beat without line end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_pix_q))
    else $error("staged item lost while output busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> !mem_req.re)
    else $error("line store written and read in one cycle");

endmodule

// File: bench/pixel_replicating_upscaler_core_checker.sv
// Scoreboard for the pixel replicating upscaler: predicts output beats and compares them.
`timescale 1ns / 1ps

module pixel_replicating_upscaler_core_checker
  import pru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                action_i,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [7:0]          red_out_i,
  input  logic [7:0]          green_out_i,
  input  logic [7:0]          blue_out_i,
  input  logic                line_end_i,
  input  logic                run_last_i,
  input  logic                status_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    pixel_t  px;
    logic    line_end;
    logic    run_last;
    status_e status;
  } beat_t;

  beat_t             pending_pixels[$];
  int                mismatch_count = 0;
  int                pending_count  = 0;

  // shadow of the block's registers and line state
  logic [ScaleW-1:0] scale_q;
  logic [WidthW-1:0] width_q;
  pixel_t            line_store_q [MaxWidth];
  int unsigned       col_q;
  int unsigned       copies_q;
  logic              replay_q;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;

  task automatic report_mismatch(input string why, input beat_t got, input beat_t want);
    mismatch_count++;
    $display("%0t %s: got %06h/%0b/%0b/%0d want %06h/%0b/%0b/%0d",
             $time, why, got.px, got.line_end, got.run_last, got.status,
             want.px, want.line_end, want.run_last, want.status);
  endtask

  // Work out the beats one accepted item causes and advance the line state.
  task automatic upscale_item(input logic act, input pixel_t px_in);
    int unsigned s;
    int unsigned w;
    int unsigned idx;
    logic        eol;
    pixel_t      px;
    beat_t       b;
    s = (scale_q == 0) ? 1 : ((scale_q > MaxScale) ? MaxScale : scale_q);
    w = (width_q == 0) ? 1 : ((width_q > MaxWidth) ? MaxWidth : width_q);
    idx = col_q % MaxWidth;
    eol = (idx + 1 >= w);
    if ((act == ActReplay) != replay_q) begin
      // wrong kind for the mode: single error beat, no state change
      b.px       = '0;
      b.line_end = 1'b0;
      b.run_last = 1'b1;
      b.status   = StatWrongKind;
      pending_pixels.push_back(b);
    end else begin
      if (replay_q) begin
        px = line_store_q[idx];
      end else begin
        px = px_in;
        line_store_q[idx] = px;
      end
      for (int unsigned k = 1; k <= s; k++) begin
        b.px       = px;
        b.line_end = eol && (k == s);
        b.run_last = (k == s);
        b.status   = StatOk;
        pending_pixels.push_back(b);
      end
      if (!eol) begin
        col_q = idx + 1;
      end else begin
        col_q = 0;
        copies_q++;
        if (copies_q >= s) begin
          copies_q = 0;
          replay_q = 1'b0;
        end else begin
          replay_q = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      scale_q  = 1;
      width_q  = 1;
      col_q    = 0;
      copies_q = 0;
      replay_q = 1'b0;
      pending_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.px       = {red_out_i, green_out_i, blue_out_i};
        got.line_end = line_end_i;
        got.run_last = run_last_i;
        got.status   = status_e'(status_i);
        if (pending_pixels.size() == 0) begin
          report_mismatch("beat with none expected", got, '0);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) report_mismatch("beat mismatch", got, want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgScale: scale_q = cfg_data_i[ScaleW-1:0];
          CfgWidth: width_q = cfg_data_i[WidthW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        upscale_item(action_i, {red_in_i, green_in_i, blue_in_i});
      end
    end
    pending_count = pending_pixels.size();
  end

endmodule

// File: bench/pixel_replicating_upscaler_core_tb.sv
// Testbench top for the pixel replicating upscaler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pixel_replicating_upscaler_core_tb;
  import pru_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 200;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic            action_i    = ActFill;
  logic [7:0]      red_in_i    = '0;
  logic [7:0]      green_in_i  = '0;
  logic [7:0]      blue_in_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      red_out_o;
  logic [7:0]      green_out_o;
  logic [7:0]      blue_out_o;
  logic            line_end_o;
  logic            run_last_o;
  logic            status_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [0:0]      cfg_index_i = CfgScale;
  logic [CfgW-1:0] cfg_data_i  = '0;

  int              mismatches;
  int              beats_pending;
  int              gap_pct      = 0;
  int              stall_pct    = 0;
  int              noise_pct    = 0;
  logic            hold_req     = 1'b0;
  int              items_sent   = 0;
  int              quiet_cycles = 0;

  pixel_replicating_upscaler_core dut (.*);

  pixel_replicating_upscaler_core_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .action_i    (action_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_i   (red_out_o),
    .green_out_i (green_out_o),
    .blue_out_i  (blue_out_o),
    .line_end_i  (line_end_o),
    .run_last_i  (run_last_o),
    .status_i    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (mismatches),
    .pending_o   (beats_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog: ends the run if no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("FAIL pixel_replicating_upscaler_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req <= 1'b0;
      end
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic pixel_t rand_pixel();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  // Valid stays high between back-to-back beats; it only drops for a gap.
  task automatic put_item(input action_e act, input pixel_t px);
    if ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sampled on the falling edge so the count settled at the last rising edge
  task automatic wait_drained();
    do @(negedge clk_i); while (beats_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    idle_input();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] s_raw, input logic [CfgW-1:0] w_raw);
    write_reg(CfgScale, s_raw);
    write_reg(CfgWidth, w_raw);
  endtask

  // One pass over a line, fill or replay, with wrong-kind noise mixed in.
  task automatic run_line(input action_e act, input int unsigned w);
    action_e wrong;
    if (act == ActFill) wrong = ActReplay;
    else wrong = ActFill;
    repeat (w) begin
      if ($urandom_range(99) < noise_pct) put_item(wrong, rand_pixel());
      put_item(act, rand_pixel());
    end
  endtask

  // Whole input lines: one fill pass then scale-1 replay passes, so every
  // replay reads entries written in the same line.
  task automatic replicate_lines(input logic [CfgW-1:0] s_raw, input logic [CfgW-1:0] w_raw,
                                 input int min_items);
    int unsigned s;
    int unsigned w;
    int          first;
    s = (s_raw == 0) ? 1 : ((s_raw > MaxScale) ? MaxScale : s_raw);
    w = (w_raw == 0) ? 1 : ((w_raw > MaxWidth) ? MaxWidth : w_raw);
    first = items_sent;
    do begin
      run_line(ActFill, w);
      repeat (s - 1) run_line(ActReplay, w);
    end while (items_sent - first < min_items);
  endtask

  initial begin
    int              phase;
    logic [CfgW-1:0] s_raw;
    logic [CfgW-1:0] w_raw;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, replay request while filling
    put_item(ActReplay, 24'hFFFFFF);
    put_item(ActFill, 24'hFFFFFF);
    put_item(ActFill, 24'h000000);
    // zero registers act as one
    configure(0, 0);
    put_item(ActFill, rand_pixel());
    // scale 3, width 2, with a fill pixel offered during replay
    configure(3, 2);
    put_item(ActFill, rand_pixel());
    put_item(ActFill, rand_pixel());
    put_item(ActFill, rand_pixel());
    repeat (4) put_item(ActReplay, rand_pixel());
    // width changed mid-line: oversize, then below the current column
    configure(2, 4);
    repeat (3) put_item(ActFill, rand_pixel());
    write_reg(CfgWidth, 11'h7FF);
    put_item(ActFill, rand_pixel());
    write_reg(CfgWidth, 2);
    put_item(ActFill, rand_pixel());
    repeat (2) put_item(ActReplay, rand_pixel());
    // scale changed mid-replay: oversize, then below the copies done
    configure(4, 2);
    repeat (2) put_item(ActFill, rand_pixel());
    repeat (2) put_item(ActReplay, rand_pixel());
    write_reg(CfgScale, 17);
    put_item(ActReplay, rand_pixel());
    write_reg(CfgScale, 2);
    put_item(ActReplay, rand_pixel());

    // random lines under changing settings and idling
    noise_pct = 10;
    for (phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 81;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 81;
        end
        default: begin
          gap_pct   = 31;
          stall_pct = 31;
        end
      endcase
      case ($urandom_range(5))
        0:       s_raw = $urandom_range(17, 31);
        1:       s_raw = 16;
        default: s_raw = $urandom_range(0, 4);
      endcase
      if (phase == 4) s_raw = 16;
      if (s_raw >= 8) w_raw = $urandom_range(0, 2);
      else if ($urandom_range(3) == 0) w_raw = $urandom_range(9, 16);
      else w_raw = $urandom_range(0, 8);
      configure(s_raw, w_raw);
      // long output hold-off while the input keeps offering beats
      if (phase == 0) hold_req <= 1'b1;
      replicate_lines(s_raw, w_raw, 10);
    end

    // back to a small setting with the scale register past the maximum
    gap_pct   = 31;
    stall_pct = 31;
    configure(31, 1);
    replicate_lines(31, 1, 10);

    idle_input();
    wait_drained();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS pixel_replicating_upscaler_core");
    end else begin
      $display("FAIL pixel_replicating_upscaler_core");
    end
    $finish;
  end

endmodule
